// File: sv/prefix_polynomial_hash_store_assert.svh
// Assertion macros for the prefix polynomial hash store checker.
`ifndef PREFIX_POLYNOMIAL_HASH_STORE_ASSERT_SVH
`define PREFIX_POLYNOMIAL_HASH_STORE_ASSERT_SVH

// Check that an expression implies another at the same edge.
`define PHS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an expression implies another at the next edge.
`define PHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/phs_pkg.sv
// Package of types and constants for the prefix polynomial hash store.
`timescale 1ns / 1ps
package phs_pkg;

    localparam int HASH_W      = 31;
    localparam int MAX_SYMBOLS = 1024;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_BASE    = 1'b0,
        CFG_MODULUS = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_MUL0,
        S_MUL0_WAIT,
        S_MUL1,
        S_MUL1_WAIT,
        S_SUB,
        S_WRITE,
        S_OUT
    } state_t;

    // Phases of the bit-serial multiplier.
    typedef enum logic [1:0] {
        M_IDLE,
        M_REDA,
        M_STEP,
        M_ADDC
    } mstate_t;

    // Handshake between the sequencer and the bit-serial multiplier.
    typedef struct packed {
        logic start;
    } mul_ctl_t;

    typedef struct packed {
        logic done;
    } mul_sts_t;

endpackage

// File: sv/phs_modmul.sv
// Bit-serial modular multiply-add: (a mod m) * b + c mod m, one bit of b per cycle.
`timescale 1ns / 1ps
module phs_modmul
    import phs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_ctl_t          ctl,
    input  logic [HASH_W-1:0] a,
    input  logic [HASH_W-1:0] b,
    input  logic [HASH_W-1:0] c,
    input  logic [HASH_W-1:0] modulus,
    output mul_sts_t          sts,
    output logic [HASH_W-1:0] result
);

    localparam int CNT_W = $clog2(HASH_W + 2);

    mstate_t           mstate_reg, mstate_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [HASH_W-1:0] a_reg, a_next;
    logic [HASH_W-1:0] b_reg, b_next;
    logic [HASH_W-1:0] c_reg, c_next;
    logic [HASH_W-1:0] rc_reg, rc_next;
    logic [HASH_W-1:0] m_reg, m_next;
    logic              done_reg, done_next;

    logic [HASH_W:0]   dbl;
    logic [HASH_W:0]   dbl_red;
    logic [HASH_W:0]   sum;
    logic [HASH_W-1:0] sum_red;
    logic [HASH_W:0]   ra_sh;
    logic [HASH_W-1:0] ra_red;
    logic [HASH_W:0]   rc_sh;
    logic [HASH_W-1:0] rc_red;
    logic [HASH_W:0]   addc;
    logic [HASH_W-1:0] addc_red;

    // Restoring remainder steps for a and c, the multiply step, and the final add.
    always_comb
    begin
        ra_sh    = {acc_reg, a_reg[HASH_W-1]};
        ra_red   = (ra_sh >= {1'b0, m_reg}) ? HASH_W'(ra_sh - {1'b0, m_reg})
                                            : HASH_W'(ra_sh);
        rc_sh    = {rc_reg, c_reg[HASH_W-1]};
        rc_red   = (rc_sh >= {1'b0, m_reg}) ? HASH_W'(rc_sh - {1'b0, m_reg})
                                            : HASH_W'(rc_sh);
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum      = dbl_red + (b_reg[HASH_W-1] ? {1'b0, a_reg} : '0);
        sum_red  = (sum >= {1'b0, m_reg}) ? HASH_W'(sum - {1'b0, m_reg})
                                          : HASH_W'(sum);
        addc     = {1'b0, acc_reg} + {1'b0, c_reg};
        addc_red = (addc >= {1'b0, m_reg}) ? HASH_W'(addc - {1'b0, m_reg})
                                           : HASH_W'(addc);
    end

    // Next phase: reduce a and c, run 31 bit steps, add c.
    always_comb
    begin
        mstate_next = mstate_reg;
        case (mstate_reg)
            M_IDLE:
            begin
                if (ctl.start)
                    mstate_next = M_REDA;
            end
            M_REDA:
            begin
                if (cnt_reg == CNT_W'(HASH_W - 1))
                    mstate_next = M_STEP;
            end
            M_STEP:
            begin
                if (cnt_reg == CNT_W'(HASH_W - 1))
                    mstate_next = M_ADDC;
            end
            M_ADDC:
            begin
                mstate_next = M_IDLE;
            end
            default:
            begin
                mstate_next = M_IDLE;
            end
        endcase
    end

    // Datapath of each phase.
    always_comb
    begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        rc_next   = rc_reg;
        m_next    = m_reg;
        done_next = 1'b0;
        case (mstate_reg)
            M_IDLE:
            begin
                if (ctl.start)
                begin
                    a_next   = a;
                    b_next   = b;
                    c_next   = c;
                    m_next   = (modulus == '0) ? HASH_W'(1) : modulus;
                    acc_next = '0;
                    rc_next  = '0;
                    cnt_next = '0;
                end
            end
            M_REDA:
            begin
                // Shift one bit of a and c into their remainders per cycle.
                if (cnt_reg == CNT_W'(HASH_W - 1))
                begin
                    a_next   = ra_red;
                    c_next   = rc_red;
                    acc_next = '0;
                    cnt_next = '0;
                end
                else
                begin
                    a_next   = {a_reg[HASH_W-2:0], 1'b0};
                    c_next   = {c_reg[HASH_W-2:0], 1'b0};
                    acc_next = ra_red;
                    rc_next  = rc_red;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            M_STEP:
            begin
                acc_next = sum_red;
                b_next   = {b_reg[HASH_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
            end
            M_ADDC:
            begin
                acc_next  = addc_red;
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstate_reg <= M_IDLE;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            mstate_reg <= mstate_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        rc_reg  <= rc_next;
        m_reg   <= m_next;
    end

    assign sts.done = done_reg;
    assign result   = acc_reg;

endmodule

// File: sv/prefix_polynomial_hash_store.sv
// Top level of the prefix polynomial hash store.
//
//  channel | direction | payload
//  s_axis  | in        | tuser op, tdata symbol/first_pos/last_pos
//  m_axis  | out       | tdata hash_value/stored_length, tuser status
//  cfg     | in        | index, data: hash_base, hash_modulus
//
// A push or a query runs two passes of the bit-serial multiplier between
// the accepting edge and the result; each pass reduces the operand, steps
// through the 31 bits of the multiplier and then adds.
// Pop, clear, a push when full and a bad query skip the multiplier.
// Reset empties the store at once.
// A waiting result holds in the output register; the next word can be taken
// in the cycle after it has gone.
`timescale 1ns / 1ps
module prefix_polynomial_hash_store
    import phs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] symbol, [17:8] first_pos, [27:18] last_pos
    input  logic [31:0]          s_axis_tdata,
    // [1:0] op
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [30:0] hash_value, [41:31] stored_length
    output logic [47:0]          m_axis_tdata,
    // [1:0] status
    output logic [1:0]           m_axis_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [HASH_W-1:0]    cfg_data
);

    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int ADDR_W = CNT_W;
    localparam int DEPTH  = MAX_SYMBOLS + 1;

    state_t             state_reg, state_next;
    logic [HASH_W-1:0]  base_reg, modulus_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    op_t                op_reg;
    logic [7:0]         sym_reg;
    logic [9:0]         first_reg, last_reg;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    status_t            status_reg, status_next;
    logic [HASH_W-1:0]  op_a_reg, op_b_reg;
    logic [HASH_W-1:0]  rdh_reg, rdp_reg;

    logic [HASH_W-1:0]  hmem [DEPTH];
    logic [HASH_W-1:0]  pmem [DEPTH];

    logic               accept;
    logic               valid_q;
    logic [CNT_W:0]     last_ext;
    logic [ADDR_W-1:0]  rd_addr_h, rd_addr_p;
    logic [CNT_W-1:0]   len;
    logic [HASH_W-1:0]  mul_a, mul_b, mul_c;
    mul_ctl_t           mctl;
    mul_sts_t           msts;
    logic [HASH_W-1:0]  mres;
    logic [HASH_W-1:0]  eff_m;
    logic [HASH_W:0]    diff;
    logic               out_valid_reg;
    logic               wr_en;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready     = 1'b1;
    assign eff_m         = (modulus_reg == '0) ? HASH_W'(1) : modulus_reg;
    assign last_ext      = (CNT_W + 1)'(last_reg);
    assign valid_q       = (first_reg <= last_reg) && (last_ext < (CNT_W + 1)'(count_reg));
    assign len           = CNT_W'({1'b0, last_reg} - {1'b0, first_reg} + 11'd1);

    // Hold configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= HASH_W'(131);
            modulus_reg <= HASH_W'(1000000007);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASE:    base_reg    <= cfg_data;
                CFG_MODULUS: modulus_reg <= cfg_data;
                default:     base_reg    <= base_reg;
            endcase
        end
    end

    // Read addresses by operation.
    always_comb
    begin
        if (op_reg == OP_QUERY)
        begin
            rd_addr_h = (state_reg == S_IDLE || state_reg == S_RD0)
                      ? ADDR_W'(first_reg) : ADDR_W'(last_ext + 1'b1);
            rd_addr_p = ADDR_W'(len);
        end
        else
        begin
            rd_addr_h = count_reg;
            rd_addr_p = count_reg;
        end
    end

    // Memories: entry zero is fixed, others are written by push.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hmem[count_reg + 1'b1] <= hash_reg;
            pmem[count_reg + 1'b1] <= op_b_reg;
        end
        rdh_reg <= (rd_addr_h == '0) ? '0 : hmem[rd_addr_h];
        rdp_reg <= (rd_addr_p == '0) ? HASH_W'(1) : pmem[rd_addr_p];
    end

    phs_modmul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mctl),
        .a       (mul_a),
        .b       (mul_b),
        .c       (mul_c),
        .modulus (modulus_reg),
        .sts     (msts),
        .result  (mres)
    );

    // Operand selection for the two multiplier passes.
    always_comb
    begin
        mctl.start = (state_reg == S_MUL0) || (state_reg == S_MUL1);
        if (op_reg == OP_PUSH)
        begin
            mul_a = (state_reg == S_MUL0) ? op_a_reg : op_b_reg;
            mul_b = base_reg;
            mul_c = (state_reg == S_MUL0) ? HASH_W'(sym_reg) : '0;
        end
        else
        begin
            // First pass forms the head term, second reduces the whole prefix.
            mul_a = (state_reg == S_MUL0) ? op_a_reg : op_b_reg;
            mul_b = (state_reg == S_MUL0) ? op_b_reg : HASH_W'(1);
            mul_c = '0;
        end
    end

    assign diff      = {1'b0, op_b_reg} + {1'b0, eff_m} - {1'b0, hash_reg};
    assign wr_en     = (state_reg == S_WRITE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (accept) state_next = S_RD0;
            S_RD0:
            begin
                if (op_reg == OP_PUSH && count_reg < CNT_W'(MAX_SYMBOLS))
                    state_next = S_RD1;
                else if (op_reg == OP_QUERY && valid_q)
                    state_next = S_RD1;
                else
                    state_next = S_OUT;
            end
            S_RD1:       state_next = S_MUL0;
            S_MUL0:      state_next = S_MUL0_WAIT;
            S_MUL0_WAIT: if (msts.done) state_next = S_MUL1;
            S_MUL1:      state_next = S_MUL1_WAIT;
            S_MUL1_WAIT: if (msts.done) state_next = (op_reg == OP_PUSH) ? S_WRITE : S_SUB;
            S_SUB:       state_next = S_OUT;
            S_WRITE:     state_next = S_OUT;
            S_OUT:       state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath outputs of each state.
    always_comb
    begin
        hash_next   = hash_reg;
        status_next = status_reg;
        count_next  = count_reg;
        case (state_reg)
            S_RD0:
            begin
                hash_next   = '0;
                status_next = ST_OK;
                case (op_reg)
                    OP_PUSH:  if (count_reg >= CNT_W'(MAX_SYMBOLS)) status_next = ST_FULL;
                    OP_POP:
                    begin
                        if (count_reg == '0) status_next = ST_EMPTY;
                        else count_next = count_reg - 1'b1;
                    end
                    OP_CLEAR: count_next = '0;
                    OP_QUERY: if (!valid_q) status_next = ST_RANGE;
                    default:  status_next = ST_OK;
                endcase
            end
            S_MUL0_WAIT: if (msts.done) hash_next = mres;
            S_SUB:
            begin
                hash_next = (diff >= {1'b0, eff_m}) ? HASH_W'(diff - {1'b0, eff_m})
                                                    : HASH_W'(diff);
            end
            S_WRITE:     count_next = count_reg + 1'b1;
            default:     hash_next = hash_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload capture; memory reads land in operand registers.
    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        status_reg <= status_next;
        if (accept)
        begin
            op_reg    <= op_t'(s_axis_tuser);
            sym_reg   <= s_axis_tdata[7:0];
            first_reg <= s_axis_tdata[17:8];
            last_reg  <= s_axis_tdata[27:18];
        end
        if (state_reg == S_RD1)
        begin
            op_a_reg <= rdh_reg;
            op_b_reg <= rdp_reg;
        end
        else if (state_reg == S_MUL0_WAIT && msts.done && op_reg == OP_QUERY)
        begin
            op_b_reg <= rdh_reg;
        end
        else if (state_reg == S_MUL1_WAIT && msts.done)
        begin
            op_b_reg <= mres;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, 11'(count_reg), hash_reg};
    assign m_axis_tuser  = status_reg;

endmodule

// File: sv/phs_checker.sv
// Port-level checker for the prefix polynomial hash store, bound to the top level.
`timescale 1ns / 1ps
`include "prefix_polynomial_hash_store_assert.svh"
module phs_checker
    import phs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // No new word while a result waits.
    `PHS_ASSERT_IMP(a_no_take_while_out, m_axis_tvalid, !s_axis_tready)
    // A result never shows in the cycle after an accept.
    `PHS_ASSERT_NEXT(a_no_instant, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
    // Failed operations give a zero hash.
    `PHS_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser != ST_OK,
                    m_axis_tdata[30:0] == 31'd0)
    // Stalled result holds.
    `PHS_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind prefix_polynomial_hash_store phs_checker u_phs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
